FILE: design/trp_pkg.sv
// Shared types and constants of the transfer ring producer.
`timescale 1ns / 1ps
`default_nettype none

package trp_pkg;

   localparam int unsigned MAX_ENTRIES = 256;
   localparam int unsigned RING_CAP = (MAX_ENTRIES > 256) ? 256 : MAX_ENTRIES;
   localparam logic [8:0] RING_LENGTH_MAX = 9'(RING_CAP);
   localparam logic [8:0] RING_LENGTH_MIN = 9'd2;
   localparam logic [8:0] RING_LENGTH_RESET = 9'd256;

   typedef enum logic [1:0] {
      CMD_COMMIT      = 2'd0,
      CMD_SET_DEQUEUE = 2'd1,
      CMD_STATUS      = 2'd2,
      CMD_RESERVED    = 2'd3
   } command_type;

   typedef struct packed {
      command_type command;
      logic        chain_bit;
      logic [7:0]  new_dequeue;
   } request_type;

   typedef struct packed {
      logic       write_valid;
      logic [7:0] write_index;
      logic       link_written;
      logic       link_chain;
      logic       link_cycle;
      logic [7:0] enqueue_index;
      logic       cycle_state;
      logic       ring_full;
      logic [7:0] free_count;
      logic       error;
   } result_type;

endpackage

`default_nettype wire

FILE: design/trp_in_stage.sv
// Input register that holds one request transaction until it is processed.
`timescale 1ns / 1ps
`default_nettype none

module trp_in_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire trp_pkg::request_type req_item,
   input  wire logic                advance,
   output logic                     item_valid,
   output trp_pkg::request_type     item
);
   import trp_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   request_type item_ff;
   logic        load;

   assign req_stall  = valid_ff && !advance;
   assign load       = !req_stall;
   assign valid_in   = load ? req_valid : valid_ff;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         item_ff <= req_item;
      end
   end

endmodule

`default_nettype wire

FILE: design/trp_ring_state.sv
// Ring state registers and the single-pass update for one request.
`timescale 1ns / 1ps
`default_nettype none

module trp_ring_state (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire trp_pkg::request_type item,
   input  wire logic                 cfg_we,
   input  wire logic [8:0]           cfg_length,
   output trp_pkg::result_type       result
);
   import trp_pkg::*;

   logic [8:0] length_ff;
   logic [7:0] enq_ff, enq_in;
   logic [7:0] deq_ff, deq_in;
   logic       cycle_ff, cycle_in;
   logic       full_ff, full_in;

   logic [8:0] length_eff;
   logic [7:0] usable;
   logic [8:0] enq_next;
   logic [8:0] busy;

   always_comb begin
      if (length_ff < RING_LENGTH_MIN) begin
         length_eff = RING_LENGTH_MIN;
      end else if (length_ff > RING_LENGTH_MAX) begin
         length_eff = RING_LENGTH_MAX;
      end else begin
         length_eff = length_ff;
      end
   end

   assign usable   = 8'(length_eff - 9'd1);
   assign enq_next = {1'b0, enq_ff} + 9'd1;

   always_comb begin
      enq_in   = enq_ff;
      deq_in   = deq_ff;
      cycle_in = cycle_ff;
      full_in  = full_ff;
      result   = '0;
      unique case (item.command)
         CMD_COMMIT: begin
            if (full_ff) begin
               result.error = 1'b1;
            end else begin
               result.write_index = enq_ff;
               result.write_valid = cycle_ff;
               if (enq_next >= {1'b0, usable}) begin
                  result.link_written = 1'b1;
                  result.link_chain   = item.chain_bit;
                  result.link_cycle   = cycle_ff;
                  cycle_in            = !cycle_ff;
                  enq_in              = 8'd0;
               end else begin
                  enq_in = enq_next[7:0];
               end
               full_in = (enq_in == deq_ff);
            end
         end
         CMD_SET_DEQUEUE: begin
            if (item.new_dequeue >= usable) begin
               result.error = 1'b1;
            end else begin
               deq_in  = item.new_dequeue;
               full_in = 1'b0;
            end
         end
         CMD_STATUS: begin
         end
         CMD_RESERVED: begin
            result.error = 1'b1;
         end
         default: begin
            result.error = 1'b1;
         end
      endcase

      if (enq_in >= deq_in) begin
         busy = {1'b0, enq_in} - {1'b0, deq_in};
      end else begin
         busy = {1'b0, enq_in} + {1'b0, usable} - {1'b0, deq_in};
      end
      result.enqueue_index = enq_in;
      result.cycle_state   = cycle_in;
      result.ring_full     = full_in;
      result.free_count    = full_in ? 8'd0 : 8'({1'b0, usable} - busy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= RING_LENGTH_RESET;
         enq_ff    <= 8'd0;
         deq_ff    <= 8'd0;
         cycle_ff  <= 1'b1;
         full_ff   <= 1'b0;
      end else if (cfg_we) begin
         length_ff <= cfg_length;
         enq_ff    <= 8'd0;
         deq_ff    <= 8'd0;
         cycle_ff  <= 1'b1;
         full_ff   <= 1'b0;
      end else if (step) begin
         enq_ff   <= enq_in;
         deq_ff   <= deq_in;
         cycle_ff <= cycle_in;
         full_ff  <= full_in;
      end
   end

   a_enq_in_ring : assert property (@(posedge clock) disable iff (reset)
      enq_ff < usable)
      else $error("Enqueue position lies outside the ring.");

   a_deq_in_ring : assert property (@(posedge clock) disable iff (reset)
      deq_ff < usable)
      else $error("Dequeue position lies outside the ring.");

   a_full_meets : assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (enq_ff == deq_ff))
      else $error("Ring is full while enqueue and dequeue differ.");

   a_cycle_toggle : assert property (@(posedge clock) disable iff (reset)
      (step && !cfg_we && !result.link_written) |=> $stable(cycle_ff))
      else $error("Cycle state changed without a link write.");

endmodule

`default_nettype wire

FILE: design/trp_out_stage.sv
// Result register that holds one response transaction until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module trp_out_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire trp_pkg::result_type result,
   output logic                     advance,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output trp_pkg::result_type      rsp_item
);
   import trp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type item_ff;

   assign advance   = !valid_ff || !rsp_stall;
   assign valid_in  = advance ? fire : valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         item_ff <= result;
      end
   end

endmodule

`default_nettype wire

FILE: design/transfer_ring_producer_unit.sv
// Top level of the transfer ring producer with request, response and CSR ports.
`timescale 1ns / 1ps
`default_nettype none

// The unit accepts one request transaction per clock cycle unless req_stall is
// raised: the request is captured in an input register, the ring update is
// done in one pass of logic, and the response is held in a result register
// until the consumer takes it. A request is taken while an earlier response
// still waits, so only a stalled response with a second request behind it
// holds off new requests. The ring length register is written through the CSR
// port only while no transaction is in flight, and each write returns the
// ring to its reset state.
module transfer_ring_producer_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_command,
   input  wire logic       req_chain_bit,
   input  wire logic [7:0] req_new_dequeue,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_write_valid,
   output logic [7:0]      rsp_write_index,
   output logic            rsp_link_written,
   output logic            rsp_link_chain,
   output logic            rsp_link_cycle,
   output logic [7:0]      rsp_enqueue_index,
   output logic            rsp_cycle_state,
   output logic            rsp_ring_full,
   output logic [7:0]      rsp_free_count,
   output logic            rsp_error,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [8:0] csr_ring_length
);
   import trp_pkg::*;

   request_type req_item;
   request_type item;
   logic        item_valid;
   logic        advance;
   logic        fire;
   logic        cfg_we;
   result_type  result;
   result_type  rsp_item;

   assign req_item.command     = command_type'(req_command);
   assign req_item.chain_bit   = req_chain_bit;
   assign req_item.new_dequeue = req_new_dequeue;

   assign fire      = item_valid && advance;
   assign csr_ready = !item_valid && !rsp_valid;
   assign cfg_we    = csr_valid && csr_ready;

   trp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   trp_ring_state u_ring_state (
      .clock      (clock),
      .reset      (reset),
      .step       (fire),
      .item       (item),
      .cfg_we     (cfg_we),
      .cfg_length (csr_ring_length),
      .result     (result)
   );

   trp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .advance   (advance),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign rsp_write_valid   = rsp_item.write_valid;
   assign rsp_write_index   = rsp_item.write_index;
   assign rsp_link_written  = rsp_item.link_written;
   assign rsp_link_chain    = rsp_item.link_chain;
   assign rsp_link_cycle    = rsp_item.link_cycle;
   assign rsp_enqueue_index = rsp_item.enqueue_index;
   assign rsp_cycle_state   = rsp_item.cycle_state;
   assign rsp_ring_full     = rsp_item.ring_full;
   assign rsp_free_count    = rsp_item.free_count;
   assign rsp_error         = rsp_item.error;

endmodule

`default_nettype wire

FILE: tb/transfer_ring_producer_checker.sv
// Checker that predicts and compares every transaction of the transfer ring producer.
`timescale 1ns / 1ps

module transfer_ring_producer_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [1:0] req_command,
   input  wire logic       req_chain_bit,
   input  wire logic [7:0] req_new_dequeue,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic       rsp_write_valid,
   input  wire logic [7:0] rsp_write_index,
   input  wire logic       rsp_link_written,
   input  wire logic       rsp_link_chain,
   input  wire logic       rsp_link_cycle,
   input  wire logic [7:0] rsp_enqueue_index,
   input  wire logic       rsp_cycle_state,
   input  wire logic       rsp_ring_full,
   input  wire logic [7:0] rsp_free_count,
   input  wire logic       rsp_error,
   input  wire logic       csr_valid,
   input  wire logic       csr_ready,
   input  wire logic [8:0] csr_ring_length,
   output int unsigned     fail_count,
   output int unsigned     results_pending
);
   import trp_pkg::*;

   logic [8:0] ring_len;
   logic [7:0] enq_slot;
   logic [7:0] deq_slot;
   logic       ring_cycle;
   logic       ring_is_full;
   result_type pending_ring_results[$];

   initial begin
      fail_count = 0;
      results_pending = 0;
   end

   function automatic void clear_ring();
      enq_slot = 8'd0;
      deq_slot = 8'd0;
      ring_cycle = 1'b1;
      ring_is_full = 1'b0;
   endfunction

   function automatic result_type advance_ring(input command_type cmd, input logic chain,
                                               input logic [7:0] new_deq);
      result_type r;
      logic [8:0] len;
      logic [8:0] usable;
      logic [8:0] next_slot;
      logic [8:0] busy;
      r = '0;
      len = ring_len;
      if (len < RING_LENGTH_MIN) len = RING_LENGTH_MIN;
      if (len > RING_LENGTH_MAX) len = RING_LENGTH_MAX;
      usable = len - 9'd1;
      case (cmd)
         CMD_COMMIT: begin
            if (ring_is_full) begin
               r.error = 1'b1;
            end else begin
               next_slot = {1'b0, enq_slot} + 9'd1;
               r.write_index = enq_slot;
               r.write_valid = ring_cycle;
               if (next_slot >= usable) begin
                  r.link_written = 1'b1;
                  r.link_chain = chain;
                  r.link_cycle = ring_cycle;
                  ring_cycle = ~ring_cycle;
                  next_slot = 9'd0;
               end
               enq_slot = next_slot[7:0];
               if (enq_slot == deq_slot) ring_is_full = 1'b1;
            end
         end
         CMD_SET_DEQUEUE: begin
            if ({1'b0, new_deq} >= usable) begin
               r.error = 1'b1;
            end else begin
               deq_slot = new_deq;
               ring_is_full = 1'b0;
            end
         end
         CMD_RESERVED: r.error = 1'b1;
         default: ;
      endcase
      r.enqueue_index = enq_slot;
      r.cycle_state = ring_cycle;
      r.ring_full = ring_is_full;
      if (ring_is_full) busy = usable;
      else if (enq_slot >= deq_slot) busy = {1'b0, enq_slot} - {1'b0, deq_slot};
      else busy = {1'b0, enq_slot} + usable - {1'b0, deq_slot};
      r.free_count = 8'(usable - busy);
      return r;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type predicted;
      if (reset) begin
         ring_len = RING_LENGTH_RESET;
         clear_ring();
         pending_ring_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            ring_len = csr_ring_length;
            clear_ring();
         end
         if (req_valid && !req_stall) begin
            predicted = advance_ring(command_type'(req_command), req_chain_bit,
                                     req_new_dequeue);
            pending_ring_results.insert(pending_ring_results.size(), predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_ring_results.size() == 0) begin
               $error("Response transaction arrived with no request outstanding.");
               fail_count++;
            end else begin
               want = pending_ring_results.pop_front();
               check_field("write_valid", want.write_valid, rsp_write_valid);
               check_field("write_index", want.write_index, rsp_write_index);
               check_field("link_written", want.link_written, rsp_link_written);
               check_field("link_chain", want.link_chain, rsp_link_chain);
               check_field("link_cycle", want.link_cycle, rsp_link_cycle);
               check_field("enqueue_index", want.enqueue_index, rsp_enqueue_index);
               check_field("cycle_state", want.cycle_state, rsp_cycle_state);
               check_field("ring_full", want.ring_full, rsp_ring_full);
               check_field("free_count", want.free_count, rsp_free_count);
               check_field("error", want.error, rsp_error);
            end
         end
      end
      results_pending <= pending_ring_results.size();
   end

endmodule

FILE: tb/transfer_ring_producer_unit_tb.sv
// Testbench top that drives the transfer ring producer and reports the verdict.
`timescale 1ns / 1ps

module transfer_ring_producer_unit_tb;
   import trp_pkg::*;

   localparam int unsigned ITEM_TARGET = 1800;
   localparam int unsigned QUIET_AFTER = 1600;
   localparam int unsigned CYCLE_LIMIT = 500000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_command;
   logic       req_chain_bit;
   logic [7:0] req_new_dequeue;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_write_valid;
   logic [7:0] rsp_write_index;
   logic       rsp_link_written;
   logic       rsp_link_chain;
   logic       rsp_link_cycle;
   logic [7:0] rsp_enqueue_index;
   logic       rsp_cycle_state;
   logic       rsp_ring_full;
   logic [7:0] rsp_free_count;
   logic       rsp_error;
   logic       csr_valid;
   logic       csr_ready;
   logic [8:0] csr_ring_length;

   int unsigned fail_count;
   int unsigned results_pending;
   int unsigned cycle_count = 0;
   int unsigned sent_count = 0;
   int unsigned csr_writes = 0;
   int unsigned usable_slots = 255;
   int unsigned stall_run = 0;
   logic        idle_on;

   transfer_ring_producer_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_chain_bit(req_chain_bit),
      .req_new_dequeue(req_new_dequeue),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_write_valid(rsp_write_valid),
      .rsp_write_index(rsp_write_index),
      .rsp_link_written(rsp_link_written),
      .rsp_link_chain(rsp_link_chain),
      .rsp_link_cycle(rsp_link_cycle),
      .rsp_enqueue_index(rsp_enqueue_index),
      .rsp_cycle_state(rsp_cycle_state),
      .rsp_ring_full(rsp_ring_full),
      .rsp_free_count(rsp_free_count),
      .rsp_error(rsp_error),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_ring_length(csr_ring_length)
   );

   transfer_ring_producer_checker ring_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_chain_bit(req_chain_bit),
      .req_new_dequeue(req_new_dequeue),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_write_valid(rsp_write_valid),
      .rsp_write_index(rsp_write_index),
      .rsp_link_written(rsp_link_written),
      .rsp_link_chain(rsp_link_chain),
      .rsp_link_cycle(rsp_link_cycle),
      .rsp_enqueue_index(rsp_enqueue_index),
      .rsp_cycle_state(rsp_cycle_state),
      .rsp_ring_full(rsp_ring_full),
      .rsp_free_count(rsp_free_count),
      .rsp_error(rsp_error),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_ring_length(csr_ring_length),
      .fail_count(fail_count),
      .results_pending(results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("transfer_ring_producer_unit regression: fail");
         $finish;
      end
   end

   // With idle_on set, response stalls come in random bursts between open stretches.
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_run <= $urandom_range(0, 30);
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(0, 17);
      end
   end

   task automatic send_request(input command_type cmd, input logic chain,
                               input logic [7:0] new_deq);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_chain_bit <= chain;
      req_new_dequeue <= new_deq;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_ring(input logic [8:0] len);
      int unsigned eff;
      drain_results();
      csr_valid <= 1'b1;
      csr_ring_length <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      eff = len;
      if (len < RING_LENGTH_MIN) eff = RING_LENGTH_MIN;
      if (len > RING_LENGTH_MAX) eff = RING_LENGTH_MAX;
      usable_slots = eff - 1;
      csr_writes++;
   endtask

   task automatic random_request(input int unsigned commit_pct, input logic phase_idle);
      int unsigned pick;
      logic        idle_now;
      logic [7:0]  new_deq;
      command_type cmd;
      idle_now = phase_idle && (sent_count < QUIET_AFTER);
      idle_on <= idle_now;
      pick = $urandom_range(0, 99);
      if (pick < commit_pct) cmd = CMD_COMMIT;
      else if (pick < commit_pct + (100 - commit_pct) * 7 / 10) cmd = CMD_SET_DEQUEUE;
      else if (pick < 97) cmd = CMD_STATUS;
      else cmd = CMD_RESERVED;
      if ($urandom_range(0, 3) == 0) new_deq = 8'($urandom_range(0, 255));
      else new_deq = 8'($urandom_range(0, usable_slots - 1));
      if (idle_now && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      send_request(cmd, 1'($urandom_range(0, 1)), new_deq);
      if ($urandom_range(0, 149) == 0) drain_results();
   endtask

   initial begin
      int unsigned pick;
      int unsigned n;
      int unsigned commit_pct;
      logic        phase_idle;
      logic [8:0]  len;
      reset <= 1'b1;
      idle_on <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_STATUS;
      req_chain_bit <= 1'b0;
      req_new_dequeue <= 8'd0;
      csr_valid <= 1'b0;
      csr_ring_length <= RING_LENGTH_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(CMD_STATUS, 1'b0, 8'd0);
      send_request(CMD_RESERVED, 1'b1, 8'hFF);
      send_request(CMD_SET_DEQUEUE, 1'b0, 8'd255);
      send_request(CMD_SET_DEQUEUE, 1'b1, 8'd254);
      send_request(CMD_COMMIT, 1'b1, 8'd0);
      send_request(CMD_COMMIT, 1'b0, 8'd0);
      send_request(CMD_SET_DEQUEUE, 1'b0, 8'd2);
      program_ring(9'd2);
      send_request(CMD_COMMIT, 1'b1, 8'd0);
      send_request(CMD_COMMIT, 1'b0, 8'd0);
      send_request(CMD_SET_DEQUEUE, 1'b0, 8'd1);
      send_request(CMD_SET_DEQUEUE, 1'b0, 8'd0);
      send_request(CMD_COMMIT, 1'b0, 8'd0);
      program_ring(9'd0);
      send_request(CMD_COMMIT, 1'b1, 8'd0);
      program_ring(9'd511);
      send_request(CMD_STATUS, 1'b1, 8'd0);
      send_request(CMD_SET_DEQUEUE, 1'b0, 8'd254);
      program_ring(9'd1);
      send_request(CMD_STATUS, 1'b0, 8'd0);
      program_ring(9'd4);
      send_request(CMD_COMMIT, 1'b1, 8'd0);
      send_request(CMD_COMMIT, 1'b0, 8'd0);
      send_request(CMD_COMMIT, 1'b1, 8'd0);
      send_request(CMD_COMMIT, 1'b0, 8'd0);
      send_request(CMD_SET_DEQUEUE, 1'b0, 8'd2);
      send_request(CMD_COMMIT, 1'b1, 8'd0);
      send_request(CMD_STATUS, 1'b0, 8'd0);

      while (sent_count < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            len = ($urandom_range(0, 1) == 0) ? RING_LENGTH_RESET : 9'($urandom_range(256, 511));
            n = $urandom_range(300, 600);
            commit_pct = 90;
         end else if (pick == 1) begin
            len = 9'($urandom_range(0, 511));
            n = $urandom_range(100, 200);
            commit_pct = 75;
         end else begin
            len = 9'($urandom_range(2, 24));
            n = $urandom_range(40, 120);
            commit_pct = 65;
         end
         phase_idle = ($urandom_range(0, 3) != 0);
         program_ring(len);
         while (n != 0 && sent_count < ITEM_TARGET) begin
            random_request(commit_pct, phase_idle);
            n--;
         end
      end

      drain_results();
      $display("Sent %0d request transactions across %0d ring length writes in %0d cycles,",
               sent_count, csr_writes, cycle_count);
      $display("covering commits, link wraps, full rings, dequeue updates and refusals.");
      if (fail_count == 0 && results_pending == 0) begin
         $display("transfer_ring_producer_unit regression: pass");
      end else begin
         $display("transfer_ring_producer_unit regression: fail");
      end
      $finish;
   end

endmodule
